// ===== sv/b64d_pkg.sv =====
// Package for the Base64 stream decoder.
// Holds the character codes, the result group type and the alphabet lookup.
// Used by b64d_decode, b64d_emit and the top level.
package b64d_pkg;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;

   localparam logic [5:0] BASE_LOWER = 6'd26;
   localparam logic [5:0] BASE_DIGIT = 6'd52;
   localparam logic [5:0] CODE_PLUS  = 6'd62;
   localparam logic [5:0] CODE_SLASH = 6'd63;

   localparam logic [1:0] CNT_NONE  = 2'd0;
   localparam logic [1:0] CNT_ONE   = 2'd1;
   localparam logic [1:0] CNT_TWO   = 2'd2;
   localparam logic [1:0] CNT_THREE = 2'd3;

   // up to three results caused by one character
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] cnt;
      logic       no_byte;
      logic       done;
   } b64d_group_type;

   // bit 6 set when the character is in the alphabet, low bits give the value
   function automatic logic [6:0] sextet_of(input logic [7:0] ch);
      logic [7:0] diff;
      begin
         diff = 8'd0;
         if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
            diff = ch - CHAR_UPPER_A;
            sextet_of = {1'b1, diff[5:0]};
         end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            diff = ch - CHAR_LOWER_A;
            sextet_of = {1'b1, diff[5:0] + BASE_LOWER};
         end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
            diff = ch - CHAR_DIGIT_0;
            sextet_of = {1'b1, diff[5:0] + BASE_DIGIT};
         end else if (ch == CHAR_PLUS) begin
            sextet_of = {1'b1, CODE_PLUS};
         end else if (ch == CHAR_SLASH) begin
            sextet_of = {1'b1, CODE_SLASH};
         end else begin
            sextet_of = 7'd0;
         end
      end
   endfunction

endpackage

// ===== sv/base64_stream_decoder_unit.sv =====
// Top level of the Base64 stream decoder: one character in, decoded bytes out.
// Instantiates b64d_decode and b64d_emit; uses b64d_pkg.
//
//   channel | direction | tdata          | tuser                        | tlast
//   req     | in        | text_char[7:0] | -                            | message_end
//   rsp     | out       | data_byte[7:0] | [0] byte_present [1] output_done | run_last
//
// A character enters the input register, is decoded combinationally, and its results
// land in the group register, which drives the rsp channel.
// One character per cycle unless its results wait for the group register; a completed
// group or two-byte flush holds rsp for its three or two bytes, back-pressuring req.
// Synchronous reset clears the input and group valids and the sextet state.
// rsp_tready low holds the current result stable and stalls req once both registers fill.
module base64_stream_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // text_char
   input  logic       req_tlast,   // message_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // data_byte
   output logic [1:0] rsp_tuser,   // byte_present, output_done
   output logic       rsp_tlast    // run_last
);
   import b64d_pkg::*;

   b64d_group_type grp;
   logic           grp_load;
   logic           grp_free;

   b64d_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .grp_free   (grp_free),
      .grp_load   (grp_load),
      .grp        (grp)
   );

   b64d_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .grp_load   (grp_load),
      .grp        (grp),
      .grp_free   (grp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sv/b64d_decode.sv =====
// Input register, sextet state and group decode for the Base64 decoder.
// Depends on b64d_pkg; feeds a result group to b64d_emit.
module b64d_decode (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // text_char
   input  logic                    req_tlast,   // message_end
   input  logic                    grp_free,
   output logic                    grp_load,
   output b64d_pkg::b64d_group_type grp
);
   import b64d_pkg::*;

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   logic [5:0] hold0_ff, hold1_ff, hold2_ff;
   logic [5:0] hold0_in, hold1_in, hold2_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pad_ff, pad_in;

   logic [6:0] sx;
   logic       is_pad, take, complete, fire;
   logic [5:0] hn0, hn1, hn2;
   logic [1:0] cn, res_cnt;
   logic       no_byte;

   always_comb begin
      sx       = sextet_of(in_char_ff);
      is_pad   = (in_char_ff == CHAR_PAD);
      take     = !pad_ff && !is_pad && sx[6];
      complete = take && (cnt_ff == CNT_THREE);
      hn0 = hold0_ff;
      hn1 = hold1_ff;
      hn2 = hold2_ff;
      cn  = cnt_ff;
      if (take && !complete) begin
         cn = cnt_ff + CNT_ONE;
         case (cnt_ff)
            CNT_NONE: hn0 = sx[5:0];
            CNT_ONE:  hn1 = sx[5:0];
            CNT_TWO:  hn2 = sx[5:0];
            default:  hn2 = hold2_ff;
         endcase
      end else if (complete) begin
         cn = CNT_NONE;
      end
      no_byte = 1'b0;
      if (complete) begin
         res_cnt = CNT_THREE;
      end else if (in_last_ff) begin
         case (cn)
            CNT_THREE: res_cnt = CNT_TWO;
            CNT_TWO:   res_cnt = CNT_ONE;
            default: begin
               res_cnt = CNT_ONE;
               no_byte = 1'b1;
            end
         endcase
      end else begin
         res_cnt = CNT_NONE;
      end
      grp.byte0   = no_byte ? 8'd0 : {hn0, hn1[5:4]};
      grp.byte1   = {hn1[3:0], hn2[5:2]};
      grp.byte2   = {hn2[1:0], sx[5:0]};
      grp.cnt     = res_cnt;
      grp.no_byte = no_byte;
      grp.done    = in_last_ff;

      fire       = in_vld_ff && ((res_cnt == CNT_NONE) || grp_free);
      grp_load   = fire && (res_cnt != CNT_NONE);
      req_tready = !in_vld_ff || fire;
      in_vld_in  = (req_tvalid && req_tready) ? 1'b1 : (fire ? 1'b0 : in_vld_ff);

      hold0_in = hold0_ff;
      hold1_in = hold1_ff;
      hold2_in = hold2_ff;
      cnt_in   = cnt_ff;
      pad_in   = pad_ff;
      if (fire) begin
         if (in_last_ff) begin
            hold0_in = 6'd0;
            hold1_in = 6'd0;
            hold2_in = 6'd0;
            cnt_in   = CNT_NONE;
            pad_in   = 1'b0;
         end else begin
            hold0_in = hn0;
            hold1_in = hn1;
            hold2_in = hn2;
            cnt_in   = cn;
            pad_in   = pad_ff || is_pad;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         hold0_ff  <= 6'd0;
         hold1_ff  <= 6'd0;
         hold2_ff  <= 6'd0;
         cnt_ff    <= CNT_NONE;
         pad_ff    <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         hold0_ff  <= hold0_in;
         hold1_ff  <= hold1_in;
         hold2_ff  <= hold2_in;
         cnt_ff    <= cnt_in;
         pad_ff    <= pad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

endmodule

// ===== sv/b64d_emit.sv =====
// Result group register and serializer for the Base64 decoder.
// Depends on b64d_pkg; takes groups from b64d_decode, drives the rsp channel.
module b64d_emit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    grp_load,
   input  b64d_pkg::b64d_group_type grp,
   output logic                    grp_free,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,   // data_byte
   output logic [1:0]              rsp_tuser,   // byte_present, output_done
   output logic                    rsp_tlast    // run_last
);
   import b64d_pkg::*;

   logic           grp_vld_ff, grp_vld_in;
   b64d_group_type grp_ff;
   logic [1:0]     idx_ff, idx_in;
   logic           last_ent;

   always_comb begin
      last_ent   = (idx_ff == (grp_ff.cnt - CNT_ONE));
      grp_free   = !grp_vld_ff || (rsp_tready && last_ent);
      rsp_tvalid = grp_vld_ff;
      rsp_tlast  = last_ent;
      rsp_tuser  = {grp_ff.done && last_ent, !grp_ff.no_byte};
      case (idx_ff)
         CNT_NONE: rsp_tdata = grp_ff.byte0;
         CNT_ONE:  rsp_tdata = grp_ff.byte1;
         CNT_TWO:  rsp_tdata = grp_ff.byte2;
         default:  rsp_tdata = 8'd0;
      endcase
      grp_vld_in = grp_vld_ff;
      idx_in     = idx_ff;
      if (grp_load) begin
         grp_vld_in = 1'b1;
         idx_in     = CNT_NONE;
      end else if (grp_vld_ff && rsp_tready) begin
         if (last_ent) begin
            grp_vld_in = 1'b0;
         end else begin
            idx_in = idx_ff + CNT_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_vld_ff <= 1'b0;
         idx_ff     <= CNT_NONE;
      end else begin
         grp_vld_ff <= grp_vld_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (grp_load) begin
         grp_ff <= grp;
      end
   end

endmodule

// ===== sv/b64d_checker.sv =====
// Port-level checks for the Base64 stream decoder top level.
// Bound to base64_stream_decoder_unit; no package needed.
module b64d_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("output_done without run_last");

   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tuser[1] && rsp_tdata == 8'd0)
      else $error("empty transaction that is not the message end");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled rsp transaction changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== verif/base64_stream_decoder_unit_test.sv =====
// Testbench for base64_stream_decoder_unit: streams Base64 text in, checks decoded bytes out.
// Predicts every result from its own decoder state and compares in order of arrival.
// Depends on b64d_pkg for the character codes and count names.
module base64_stream_decoder_unit_test;
   import b64d_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic [7:0] gap;
   } text_item_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       run_last;
      logic       output_done;
   } decoded_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   text_item_type    text_pending[$];
   logic [7:0]       msg_chars[$];
   decoded_byte_type decoded_bytes_due[$];

   logic [5:0] held_sextets [3] = '{6'd0, 6'd0, 6'd0};
   logic [1:0] held_count = CNT_NONE;
   logic       pad_flag = 1'b0;

   logic             req_fire = 1'b0;
   text_item_type    next_char;
   decoded_byte_type got_byte;
   decoded_byte_type want_byte;
   int               send_wait = 0;
   int               ready_wait = 0;
   int               long_hold_left = 0;
   int               long_holds = 0;
   int               ready_cycle = 0;
   int               chars_queued = 0;
   int               chars_accepted = 0;
   int               results_due = 0;
   int               rsp_seen = 0;
   int               mismatches = 0;

   base64_stream_decoder_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic int sextet_value(input logic [7:0] ch);
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) return int'(ch - CHAR_UPPER_A);
      if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) return int'(ch - CHAR_LOWER_A) + 26;
      if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) return int'(ch - CHAR_DIGIT_0) + 52;
      if (ch == CHAR_PLUS) return 62;
      if (ch == CHAR_SLASH) return 63;
      return -1;
   endfunction

   function automatic logic [7:0] alphabet_char(input logic [5:0] v);
      if (v < 6'd26) return CHAR_UPPER_A + 8'(v);
      if (v < 6'd52) return CHAR_LOWER_A + 8'(v - 6'd26);
      if (v < 6'd62) return CHAR_DIGIT_0 + 8'(v - 6'd52);
      if (v == CODE_PLUS) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   function automatic logic [7:0] pick_noise();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (sextet_value(c) >= 0 || c == CHAR_PAD);
      return c;
   endfunction

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   function automatic decoded_byte_type byte_result(input logic [7:0] b, input logic present);
      decoded_byte_type r;
      r = '0;
      r.data_byte = b;
      r.byte_present = present;
      return r;
   endfunction

   task automatic predict_decode(input logic [7:0] ch, input logic last);
      decoded_byte_type group [3];
      int               n;
      int               v;
      logic [5:0]       s;
      n = 0;
      if (!pad_flag) begin
         if (ch == CHAR_PAD) begin
            pad_flag = 1'b1;
         end else begin
            v = sextet_value(ch);
            if (v >= 0) begin
               s = v[5:0];
               if (held_count == CNT_THREE) begin
                  group[0] = byte_result({held_sextets[0], held_sextets[1][5:4]}, 1'b1);
                  group[1] = byte_result({held_sextets[1][3:0], held_sextets[2][5:2]}, 1'b1);
                  group[2] = byte_result({held_sextets[2][1:0], s}, 1'b1);
                  n = 3;
                  held_count = CNT_NONE;
               end else begin
                  held_sextets[held_count] = s;
                  held_count = held_count + 2'd1;
               end
            end
         end
      end
      if (last) begin
         if (held_count >= CNT_TWO) begin
            group[n] = byte_result({held_sextets[0], held_sextets[1][5:4]}, 1'b1);
            n = n + 1;
         end
         if (held_count == CNT_THREE) begin
            group[n] = byte_result({held_sextets[1][3:0], held_sextets[2][5:2]}, 1'b1);
            n = n + 1;
         end
         if (n == 0) begin
            group[0] = byte_result(8'h00, 1'b0);
            n = 1;
         end
         group[n-1].output_done = 1'b1;
         held_sextets = '{6'd0, 6'd0, 6'd0};
         held_count = CNT_NONE;
         pad_flag = 1'b0;
      end
      if (n > 0) group[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) begin
         decoded_bytes_due = {decoded_bytes_due, group[i]};
         results_due = results_due + 1;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
      mismatches = mismatches + 1;
   endtask

   task automatic add_char(input logic [7:0] ch);
      msg_chars = {msg_chars, ch};
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endtask

   task automatic flush_message(input bit quiet);
      text_item_type item;
      while (msg_chars.size() > 0) begin
         item.ch = msg_chars.pop_front();
         item.last = (msg_chars.size() == 0);
         item.gap = quiet ? 8'd0 : 8'(random_gap());
         text_pending = {text_pending, item};
         chars_queued = chars_queued + 1;
      end
   endtask

   task automatic add_encoded(input int nbytes, input bit with_pad, input bit noisy);
      logic [23:0] chunk;
      int          left;
      int          nchars;
      for (int i = 0; i < nbytes; i += 3) begin
         left = nbytes - i;
         chunk = 24'($urandom);
         if (left < 3) chunk[7:0] = 8'h00;
         if (left < 2) chunk[15:8] = 8'h00;
         nchars = (left >= 3) ? 4 : left + 1;
         for (int k = 0; k < nchars; k++) begin
            if (noisy && $urandom_range(0, 7) == 0) add_char(pick_noise());
            add_char(alphabet_char(chunk[23 - 6*k -: 6]));
         end
         if (left < 3 && with_pad)
            for (int k = nchars; k < 4; k++) add_char(CHAR_PAD);
      end
   endtask

   // sender: hold each character until taken, then idle for its gap
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (send_wait > 0) begin
            send_wait = send_wait - 1;
            req_tvalid <= 1'b0;
         end else if (text_pending.size() > 0) begin
            next_char = text_pending.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= next_char.ch;
            req_tlast <= next_char.last;
            send_wait = next_char.gap;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, quiet stretches, and two long hold-offs
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         ready_cycle = ready_cycle + 1;
         if (long_hold_left > 0) begin
            long_hold_left = long_hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (long_holds < 2 && rsp_seen >= 25 + 65 * long_holds) begin
            long_holds = long_holds + 1;
            long_hold_left = 59;
            rsp_tready <= 1'b0;
         end else if (ready_wait > 0) begin
            ready_wait = ready_wait - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            ready_wait = ((ready_cycle / 150) % 3 == 0) ? 0 : random_gap();
         end
      end
   end

   always @(posedge clock) begin
      req_fire <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_decode(req_tdata, req_tlast);
            chars_accepted = chars_accepted + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen = rsp_seen + 1;
            got_byte.data_byte = rsp_tdata;
            got_byte.byte_present = rsp_tuser[0];
            got_byte.output_done = rsp_tuser[1];
            got_byte.run_last = rsp_tlast;
            if (decoded_bytes_due.size() == 0) begin
               report_mismatch("unexpected transaction", int'(got_byte), 0);
            end else begin
               want_byte = decoded_bytes_due.pop_front();
               results_due = results_due - 1;
               if (got_byte.data_byte !== want_byte.data_byte)
                  report_mismatch("data_byte", got_byte.data_byte, want_byte.data_byte);
               if (got_byte.byte_present !== want_byte.byte_present)
                  report_mismatch("byte_present", got_byte.byte_present,
                                  want_byte.byte_present);
               if (got_byte.run_last !== want_byte.run_last)
                  report_mismatch("run_last", got_byte.run_last, want_byte.run_last);
               if (got_byte.output_done !== want_byte.output_done)
                  report_mismatch("output_done", got_byte.output_done,
                                  want_byte.output_done);
            end
         end
      end
   end

   initial begin
      int  kind;
      bit  quiet;
      int  len;
      add_text("A");
      flush_message(1'b0);
      add_text("////");
      flush_message(1'b1);
      add_text("zz9");
      flush_message(1'b0);
      add_char(8'hFF);
      flush_message(1'b0);
      add_text("Za@[`{09:+");
      add_char(8'h00);
      add_text("/");
      flush_message(1'b0);
      add_text("Q=QQ");
      flush_message(1'b1);

      while (chars_queued < 125) begin
         kind = $urandom_range(0, 99);
         quiet = ($urandom_range(0, 3) == 0);
         if (kind < 70) begin
            add_encoded($urandom_range(0, 9), $urandom_range(0, 2) != 0,
                        $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) add_char(alphabet_char(6'($urandom_range(0, 63))));
            if (msg_chars.size() == 0) add_char(pick_noise());
         end else if (kind < 85) begin
            len = $urandom_range(1, 7);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 9) == 0) add_char(CHAR_PAD);
               else add_char(alphabet_char(6'($urandom_range(0, 63))));
            end
         end else begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) add_char(8'($urandom_range(0, 255)));
         end
         flush_message(quiet);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (chars_accepted == chars_queued && results_due == 0);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && decoded_bytes_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/b64d_pkg.sv
sv/b64d_decode.sv
sv/b64d_emit.sv
sv/base64_stream_decoder_unit.sv
sv/b64d_checker.sv
verif/base64_stream_decoder_unit_test.sv
